/* hw/rtl/iir_biquad_cascade_df1_assert.svh */
// Assertion macros shared by the checker of the biquad cascade.
// No dependencies; included by files that carry concurrent assertions.
`ifndef IIR_BIQUAD_CASCADE_DF1_ASSERT_SVH
`define IIR_BIQUAD_CASCADE_DF1_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BQC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bqc assertion failed");

// next-cycle implication, disabled during reset
`define BQC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bqc assertion failed");

// next-cycle implication that also holds across reset
`define BQC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bqc assertion failed");

`endif

/* hw/rtl/bqc_pkg.sv */
// Package for the biquad cascade: widths, payload types, coefficient table,
// control structs and the sample saturation function. No dependencies.
package bqc_pkg;

  localparam int SECTIONS    = 3;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 32;
  localparam int COEF_FRAC   = COEF_BITS - 2;
  localparam int DELAY_BITS  = 32;
  localparam int NCOEF       = 5;
  localparam int TAPS        = 4;
  localparam int TAP_W       = 2;
  localparam int SEC_W       = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int ADDR_W      = SEC_W + TAP_W;
  localparam int MEM_DEPTH   = SECTIONS * TAPS;
  localparam int PROD_BITS   = DELAY_BITS + COEF_BITS;
  localparam int ACC_BITS    = PROD_BITS + 3;

  // delay-line entries of one section
  localparam logic [TAP_W-1:0] TAP_X1 = 2'd0;
  localparam logic [TAP_W-1:0] TAP_X2 = 2'd1;
  localparam logic [TAP_W-1:0] TAP_Y1 = 2'd2;
  localparam logic [TAP_W-1:0] TAP_Y2 = 2'd3;

  // per section, Q2.30: b0, b1, b2, -a1, -a2
  localparam logic signed [COEF_BITS-1:0] COEF_TBL [SECTIONS][NCOEF] = '{
    '{ 32'sd368938346,   32'sd737876691,  32'sd368938346,
      -32'sd193213216,  -32'sd8691886 },
    '{ 32'sd1073741824, -32'sd2147483648, 32'sd1073741824,
       32'sd1979963731, -32'sd909257193 },
    '{ 32'sd1073741824, -32'sd2147483648, 32'sd1073741824,
       32'sd2138817284, -32'sd1065092941 }
  };

  typedef struct packed {
    logic                          action;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          block_end;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          status;
    logic                          block_end_out;
  } out_t;

  typedef struct packed {
    logic                         we;
    logic [ADDR_W-1:0]            waddr;
    logic signed [DELAY_BITS-1:0] wdata;
    logic                         re;
    logic [ADDR_W-1:0]            raddr;
  } mem_req_t;

  typedef struct packed {
    logic mul;
    logic load;
    logic add;
  } mac_ctrl_t;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [DELAY_BITS-1:0] v
  );
    logic signed [DELAY_BITS-1:0] hi;
    logic signed [DELAY_BITS-1:0] lo;
    hi = (DELAY_BITS'(1) <<< (SAMPLE_BITS - 1)) - DELAY_BITS'(1);
    lo = -hi - DELAY_BITS'(1);
    if (v > hi) begin
      return SAMPLE_BITS'(hi);
    end else if (v < lo) begin
      return SAMPLE_BITS'(lo);
    end
    return SAMPLE_BITS'(v);
  endfunction

endpackage

/* hw/rtl/bqc_state_ram.sv */
// Delay-line store of the cascade: one write port, one registered read port.
// Depends on bqc_pkg.
module bqc_state_ram import bqc_pkg::*; (
  input  logic                         clk,
  input  mem_req_t                     req,
  output logic signed [DELAY_BITS-1:0] rdata
);

  logic signed [DELAY_BITS-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

/* hw/rtl/bqc_mac.sv */
// Shared multiply-accumulate of the cascade with rounding and 32-bit saturation.
// Depends on bqc_pkg.
module bqc_mac import bqc_pkg::*; (
  input  logic                         clk,
  input  mac_ctrl_t                    ctrl,
  input  logic signed [DELAY_BITS-1:0] a,
  input  logic signed [COEF_BITS-1:0]  c,
  output logic signed [DELAY_BITS-1:0] y
);

  localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [ACC_BITS-1:0] DMAX =
    (ACC_BITS'(1) <<< (DELAY_BITS - 1)) - ACC_BITS'(1);
  localparam logic signed [ACC_BITS-1:0] DMIN = -DMAX - ACC_BITS'(1);

  logic signed [PROD_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS-1:0]  rnd;
  logic signed [ACC_BITS-1:0]  q;

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= PROD_BITS'(a) * PROD_BITS'(c);
    end
    if (ctrl.load) begin
      acc <= ACC_BITS'(prod);
    end else if (ctrl.add) begin
      acc <= acc + ACC_BITS'(prod);
    end
  end

  // round to nearest, ties up, then clamp to the delay width
  always_comb begin
    rnd = acc + HALF;
    q   = rnd >>> COEF_FRAC;
    if (q > DMAX) begin
      y = DELAY_BITS'(DMAX);
    end else if (q < DMIN) begin
      y = DELAY_BITS'(DMIN);
    end else begin
      y = DELAY_BITS'(q);
    end
  end

endmodule

/* hw/rtl/bqc_seq.sv */
// Sequencer of the cascade: clearing sweep, per-section read/MAC/write-back
// schedule and the pending result. Depends on bqc_pkg.
module bqc_seq import bqc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         filters_ready,
  input  logic                         req_valid,
  input  in_t                          req,
  output logic                         req_stall,
  output logic                         done,
  output out_t                         res,
  input  logic                         take,
  output mem_req_t                     mreq,
  input  logic signed [DELAY_BITS-1:0] rdata,
  output mac_ctrl_t                    ctrl,
  output logic signed [DELAY_BITS-1:0] mac_a,
  output logic signed [COEF_BITS-1:0]  mac_c,
  input  logic signed [DELAY_BITS-1:0] mac_y
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [2:0] PH_MUL_LAST = 3'd4;
  localparam logic [2:0] PH_ACC_LAST = 3'd5;
  localparam logic [2:0] PH_LAST     = 3'd6;
  localparam logic [2:0] PH_RD_LAST  = 3'd3;

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MEM_DEPTH - 1);
  localparam logic [SEC_W-1:0]  SEC_LAST = SEC_W'(SECTIONS - 1);

  logic [1:0]                   state;
  logic [SEC_W-1:0]             sec;
  logic [2:0]                   ph;
  logic [ADDR_W-1:0]            clr_cnt;
  logic                         clr_emit;
  logic signed [DELAY_BITS-1:0] x;
  logic signed [DELAY_BITS-1:0] x1_sv;
  logic signed [DELAY_BITS-1:0] y1_sv;
  logic [2:0]                   cidx;
  logic                         accept;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign done      = (state == ST_DONE);
  assign cidx      = (ph <= PH_MUL_LAST) ? ph : 3'd0;

  always_comb begin
    mreq  = '0;
    ctrl  = '0;
    mac_a = (ph == 3'd0) ? x : rdata;
    mac_c = COEF_TBL[sec][cidx];
    case (state)
      ST_CLEAR: begin
        mreq.we    = 1'b1;
        mreq.waddr = clr_cnt;
        mreq.wdata = '0;
      end
      ST_RUN: begin
        // reads of x1, x2, y1, y2 come back from the registered port as operands in the next phase
        mreq.re    = (ph <= PH_RD_LAST);
        mreq.raddr = {sec, ph[TAP_W-1:0]};
        ctrl.mul   = (ph <= PH_MUL_LAST);
        ctrl.load  = (ph == 3'd1);
        ctrl.add   = (ph >= 3'd2) && (ph <= PH_ACC_LAST);
        // each write lands after that entry's read has been taken
        case (ph)
          3'd1: begin
            mreq.we    = 1'b1;
            mreq.waddr = {sec, TAP_X1};
            mreq.wdata = x;
          end
          3'd2: begin
            mreq.we    = 1'b1;
            mreq.waddr = {sec, TAP_X2};
            mreq.wdata = x1_sv;
          end
          3'd4: begin
            mreq.we    = 1'b1;
            mreq.waddr = {sec, TAP_Y2};
            mreq.wdata = y1_sv;
          end
          PH_LAST: begin
            mreq.we    = 1'b1;
            mreq.waddr = {sec, TAP_Y1};
            mreq.wdata = mac_y;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      clr_emit <= 1'b0;
      sec      <= '0;
      ph       <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == CLR_LAST) begin
            state <= clr_emit ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            sec <= '0;
            ph  <= '0;
            if (req.action) begin
              state    <= ST_CLEAR;
              clr_cnt  <= '0;
              clr_emit <= 1'b1;
            end else if (!filters_ready) begin
              state <= ST_DONE;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (ph == PH_LAST) begin
            ph <= '0;
            if (sec == SEC_LAST) begin
              state <= ST_DONE;
            end else begin
              sec <= sec + SEC_W'(1);
            end
          end else begin
            ph <= ph + 3'd1;
          end
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x                 <= DELAY_BITS'(req.sample_in);
      res.sample_out    <= '0;
      res.status        <= !req.action && !filters_ready;
      res.block_end_out <= req.block_end;
    end
    if (state == ST_RUN) begin
      if (ph == 3'd1) begin
        x1_sv <= rdata;
      end
      if (ph == 3'd3) begin
        y1_sv <= rdata;
      end
      if (ph == PH_LAST) begin
        x <= mac_y;
        if (sec == SEC_LAST) begin
          res.sample_out <= sat_sample(mac_y);
        end
      end
    end
  end

endmodule

/* hw/rtl/iir_biquad_cascade_df1.sv */
// Top level of the three-section direct-form-1 biquad cascade.
// Depends on bqc_pkg, bqc_state_ram, bqc_mac and bqc_seq.
//
// channel  direction  handshake              payload
// req      in         req_valid / req_stall  req  (in_t: action, sample_in, block_end)
// rsp      out        rsp_valid / rsp_stall  rsp  (out_t: sample_out, status, block_end_out)
// cfg      in         cfg_we                 cfg_wdata (filters_ready)
//
// Filtering: each section computes five products through the one MAC, then
// accumulates and rounds, section by section; rsp_valid rises when the result
// moves into the output register, and the next request is taken only after.
// A clear zeroes the 12 delay entries one a cycle, then answers. A rejected
// sample (filters_ready low) goes straight to its response. Reset runs the
// clearing pass with req_stall high. A stalled output holds its transaction;
// a result finished meanwhile waits with req_stall high.
module iir_biquad_cascade_df1 import bqc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  in_t  req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output out_t rsp,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  logic                         filters_ready;
  logic                         done;
  logic                         take;
  out_t                         res;
  mem_req_t                     mreq;
  logic signed [DELAY_BITS-1:0] rdata;
  mac_ctrl_t                    ctrl;
  logic signed [DELAY_BITS-1:0] mac_a;
  logic signed [COEF_BITS-1:0]  mac_c;
  logic signed [DELAY_BITS-1:0] mac_y;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      filters_ready <= 1'b0;
    end else if (cfg_we) begin
      filters_ready <= cfg_wdata;
    end
  end

  // output register: the finished result moves over once the slot is free
  assign take = done && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= res;
    end
  end

  bqc_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .filters_ready (filters_ready),
    .req_valid     (req_valid),
    .req           (req),
    .req_stall     (req_stall),
    .done          (done),
    .res           (res),
    .take          (take),
    .mreq          (mreq),
    .rdata         (rdata),
    .ctrl          (ctrl),
    .mac_a         (mac_a),
    .mac_c         (mac_c),
    .mac_y         (mac_y)
  );

  bqc_state_ram u_ram (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  bqc_mac u_mac (
    .clk  (clk),
    .ctrl (ctrl),
    .a    (mac_a),
    .c    (mac_c),
    .y    (mac_y)
  );

endmodule

/* hw/rtl/bqc_checker.sv */
// Port-level checker for the biquad cascade, bound to the top level.
// Depends on bqc_pkg and iir_biquad_cascade_df1_assert.svh.
`include "iir_biquad_cascade_df1_assert.svh"

module bqc_checker import bqc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input out_t rsp
);

  // one transaction in flight: busy right after taking a request
  `BQC_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall)

  // reset starts the clearing pass, so requests are held off
  `BQC_ASSERT_NEXT_ALWAYS(a_clear_after_reset, clk, rst, req_stall)

  // not-ready status carries a zero sample
  `BQC_ASSERT_IMPLY(a_reject_zero, clk, rst, rsp_valid && rsp.status, rsp.sample_out == '0)

  // stalled result holds
  `BQC_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind iir_biquad_cascade_df1 bqc_checker u_bqc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
